// File: src/fvas_pkg.sv
// shared constants for the frame voice activity score block
package fvas_pkg;

  // default longest frame that is accumulated
  localparam int MAX_FRAME_DEFAULT = 512;

  // full-scale square of a Q1.15 sample is 2^30
  localparam int Q15_SQ_SHIFT = 30;
  localparam int MAG_W        = 16;

  // energy window: 0.01 < rms < 0.3, squared and cross-multiplied
  localparam int ENERGY_LO_MUL = 10000;
  localparam int ENERGY_HI_MUL = 100;
  localparam int ENERGY_HI_N   = 9;

  // crossing rate window: 0.02 < c/(n-1) < 0.2
  localparam int CROSS_LO_MUL = 50;
  localparam int CROSS_HI_MUL = 5;

  // centroid window: 0.2 < w/(m*n) < 0.8
  localparam int CENTROID_W_MUL  = 5;
  localparam int CENTROID_HI_MUL = 4;

  // feature weights in tenths
  localparam int WEIGHT_ENERGY   = 3;
  localparam int WEIGHT_CROSSING = 3;
  localparam int WEIGHT_CENTROID = 2;

endpackage

// File: src/frame_voice_activity_score.sv
// frame voice activity score: per-frame energy, crossing rate and centroid tests
//
//   channel   signals                          direction  transaction
//   sample    sample, last_in_frame            in         one audio sample
//   score     score_tenths, energy_ok,         out        one result per frame,
//             crossing_ok, centroid_ok                    after the flagged sample
//
// one sample is taken every cycle while the score output is not stalled; a frame's
// result passes five registers (input register, product stage, accumulator stage,
// threshold product stage, output register) before it is offered
// rst is synchronous and clears the frame counter, the accumulators and all valid bits
// the whole pipeline advances whenever the output register is empty or being taken,
// so a stalled score holds every stage and sample_ready falls with it
module frame_voice_activity_score #(
  parameter int MAX_FRAME = fvas_pkg::MAX_FRAME_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  logic signed [15:0] sample,
  input  logic               last_in_frame,
  output logic               score_valid,
  input  logic               score_ready,
  output logic        [3:0]  score_tenths,
  output logic               energy_ok,
  output logic               crossing_ok,
  output logic               centroid_ok
);

  localparam int CW    = $clog2(MAX_FRAME + 1);
  localparam int MAGW  = fvas_pkg::MAG_W;
  localparam int SQ1W  = fvas_pkg::Q15_SQ_SHIFT + 1;
  localparam int WTW   = 15 + CW;
  localparam int SQW   = fvas_pkg::Q15_SQ_SHIFT + CW;
  localparam int MW    = 15 + CW;
  localparam int WW    = 14 + 2 * CW;
  localparam int EW    = SQW + 14;
  localparam int EHW   = SQW + 7;
  localparam int C50W  = CW + 6;
  localparam int C5W   = CW + 3;
  localparam int MNW   = MW + CW;
  localparam int CMPW  = WW + 3;
  localparam int NINEW = CW + 4;

  logic advance;
  logic accept;

  assign advance      = !score_valid || score_ready;
  assign sample_ready = advance;
  assign accept       = sample_valid && sample_ready;

  // front end: frame index and sign tracking
  logic [CW-1:0] cnt;
  logic          prev_nonneg;
  logic          in_nonneg;
  logic          in_take;
  logic          in_cross;
  logic [CW-1:0] in_count;

  always_comb begin
    in_nonneg = !sample[15];
    in_take   = cnt < CW'(MAX_FRAME);
    in_cross  = in_take && (cnt != '0) && (in_nonneg != prev_nonneg);
    in_count  = in_take ? cnt + CW'(1) : cnt;
  end

  logic                s0_valid;
  logic [15:0]         s0_sample;
  logic                s0_last;
  logic                s0_take;
  logic                s0_cross;
  logic [CW-1:0]       s0_index;
  logic [CW-1:0]       s0_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      prev_nonneg <= 1'b0;
      s0_valid    <= 1'b0;
    end else if (advance) begin
      s0_valid <= accept;
      if (accept) begin
        cnt         <= last_in_frame ? '0 : in_count;
        prev_nonneg <= last_in_frame ? 1'b0 : (in_take ? in_nonneg : prev_nonneg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_sample <= sample;
      s0_last   <= last_in_frame;
      s0_take   <= in_take;
      s0_cross  <= in_cross;
      s0_index  <= cnt;
      s0_count  <= in_count;
    end
  end

  // product stage: magnitude, its square and its index weight
  logic [16:0]        mag_full;
  logic [33:0]        sq_full;
  logic [16+CW:0]     wt_full;

  always_comb begin
    mag_full = s0_sample[15] ? (17'h10000 - {1'b0, s0_sample}) : {1'b0, s0_sample};
    sq_full  = {17'd0, mag_full} * {17'd0, mag_full};
    wt_full  = {{CW{1'b0}}, mag_full} * {17'd0, s0_index};
  end

  logic             s1_valid;
  logic             s1_last;
  logic             s1_take;
  logic             s1_cross;
  logic [CW-1:0]    s1_count;
  logic [MAGW-1:0]  s1_mag;
  logic [SQ1W-1:0]  s1_square;
  logic [WTW-1:0]   s1_weighted;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s0_valid) begin
      s1_last     <= s0_last;
      s1_take     <= s0_take;
      s1_cross    <= s0_cross;
      s1_count    <= s0_count;
      s1_mag      <= mag_full[MAGW-1:0];
      s1_square   <= sq_full[SQ1W-1:0];
      s1_weighted <= wt_full[WTW-1:0];
    end
  end

  // accumulator stage: frame sums, handed on and cleared at the frame end
  logic [SQW-1:0] sq_acc;
  logic [MW-1:0]  mag_acc;
  logic [WW-1:0]  wmag_acc;
  logic [CW-1:0]  cross_acc;
  logic [SQW-1:0] sq_sum;
  logic [MW-1:0]  mag_sum;
  logic [WW-1:0]  wmag_sum;
  logic [CW-1:0]  cross_sum;

  always_comb begin
    sq_sum    = sq_acc + (s1_take ? SQW'(s1_square) : '0);
    mag_sum   = mag_acc + (s1_take ? MW'(s1_mag) : '0);
    wmag_sum  = wmag_acc + (s1_take ? WW'(s1_weighted) : '0);
    cross_sum = cross_acc + (s1_cross ? CW'(1) : '0);
  end

  logic           s2_valid;
  logic [SQW-1:0] s2_square;
  logic [MW-1:0]  s2_mag;
  logic [WW-1:0]  s2_wmag;
  logic [CW-1:0]  s2_cross;
  logic [CW-1:0]  s2_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_acc    <= '0;
      mag_acc   <= '0;
      wmag_acc  <= '0;
      cross_acc <= '0;
      s2_valid  <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1_last;
      if (s1_valid) begin
        sq_acc    <= s1_last ? '0 : sq_sum;
        mag_acc   <= s1_last ? '0 : mag_sum;
        wmag_acc  <= s1_last ? '0 : wmag_sum;
        cross_acc <= s1_last ? '0 : cross_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && s1_last) begin
      s2_square <= sq_sum;
      s2_mag    <= mag_sum;
      s2_wmag   <= wmag_sum;
      s2_cross  <= cross_sum;
      s2_count  <= s1_count;
    end
  end

  // threshold product stage: constant scalings and magnitude times count
  logic            s3_valid;
  logic [EW-1:0]   s3_sq_lo;
  logic [EHW-1:0]  s3_sq_hi;
  logic [CW-1:0]   s3_count;
  logic [C50W-1:0] s3_cross_lo;
  logic [C5W-1:0]  s3_cross_hi;
  logic [MNW-1:0]  s3_mn;
  logic [CMPW-1:0] s3_w5;
  logic            s3_mag_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      s3_sq_lo    <= EW'(s2_square) * EW'(fvas_pkg::ENERGY_LO_MUL);
      s3_sq_hi    <= EHW'(s2_square) * EHW'(fvas_pkg::ENERGY_HI_MUL);
      s3_count    <= s2_count;
      s3_cross_lo <= C50W'(s2_cross) * C50W'(fvas_pkg::CROSS_LO_MUL);
      s3_cross_hi <= C5W'(s2_cross) * C5W'(fvas_pkg::CROSS_HI_MUL);
      s3_mn       <= MNW'(s2_mag) * MNW'(s2_count);
      s3_w5       <= CMPW'(s2_wmag) * CMPW'(fvas_pkg::CENTROID_W_MUL);
      s3_mag_nz   <= s2_mag != '0;
    end
  end

  // compare stage: window tests and weighted score
  logic [NINEW-1:0] nine_n;
  logic [EW-1:0]    e_lo_ref;
  logic [EW-1:0]    e_hi_ref;
  logic [CW-1:0]    gaps;
  logic [CMPW-1:0]  mn_ext;
  logic [CMPW-1:0]  mn4;
  logic             e_hit;
  logic             z_hit;
  logic             c_hit;

  always_comb begin
    nine_n   = NINEW'(s3_count) * NINEW'(fvas_pkg::ENERGY_HI_N);
    e_lo_ref = EW'({s3_count, {fvas_pkg::Q15_SQ_SHIFT{1'b0}}});
    e_hi_ref = EW'({nine_n, {fvas_pkg::Q15_SQ_SHIFT{1'b0}}});
    e_hit    = (s3_sq_lo > e_lo_ref) && (EW'(s3_sq_hi) < e_hi_ref);
    gaps     = s3_count - CW'(1);
    z_hit    = (s3_count >= CW'(2)) && (s3_cross_lo > C50W'(gaps))
               && (s3_cross_hi < C5W'(gaps));
    mn_ext   = CMPW'(s3_mn);
    mn4      = CMPW'(s3_mn) * CMPW'(fvas_pkg::CENTROID_HI_MUL);
    c_hit    = s3_mag_nz && (s3_w5 > mn_ext) && (s3_w5 < mn4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_valid <= 1'b0;
    end else if (advance) begin
      score_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s3_valid) begin
      energy_ok    <= e_hit;
      crossing_ok  <= z_hit;
      centroid_ok  <= c_hit;
      score_tenths <= (e_hit ? 4'(fvas_pkg::WEIGHT_ENERGY) : 4'd0)
                    + (z_hit ? 4'(fvas_pkg::WEIGHT_CROSSING) : 4'd0)
                    + (c_hit ? 4'(fvas_pkg::WEIGHT_CENTROID) : 4'd0);
    end
  end

  // frame counter restarts after the flagged sample
  a_cnt_restart: assert property (@(posedge clk) disable iff (rst)
    accept && last_in_frame |=> cnt == '0)
    else $error("frame counter not cleared after last sample");

  // frame counter saturates at the longest frame
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_FRAME))
    else $error("frame counter beyond longest frame");

  // crossings can never outnumber the samples of a frame
  a_cross_bound: assert property (@(posedge clk) disable iff (rst)
    cross_acc <= CW'(MAX_FRAME))
    else $error("crossing count beyond longest frame");

  // a compared frame always lands in the output register
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    s3_valid && advance |=> score_valid)
    else $error("frame result lost before output register");

endmodule

// File: bench/frame_voice_activity_score_tb.sv
// self-checking testbench for the frame voice activity score block
`timescale 1ns / 100ps

module frame_voice_activity_score_tb;

  localparam int FRAME_CAP     = 512;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int TAIL_ITEMS    = 200;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_TRIGGER  = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 200000;

  // feature weights, in tenths
  localparam int W_ENERGY   = 3;
  localparam int W_CROSSING = 3;
  localparam int W_CENTROID = 2;

  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
  } audio_txn_t;

  typedef struct packed {
    logic [3:0] score;
    logic       energy;
    logic       crossing;
    logic       centroid;
  } frame_score_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               sample_valid = 1'b0;
  logic               sample_ready;
  logic signed [15:0] sample = '0;
  logic               last_in_frame = 1'b0;
  logic               score_valid;
  logic               score_ready = 1'b0;
  logic        [3:0]  score_tenths;
  logic               energy_ok;
  logic               crossing_ok;
  logic               centroid_ok;

  audio_txn_t   pending_samples[$];
  frame_score_t expected_scores[$];

  // frame accumulators of the predictor
  logic [9:0]  frame_len;
  logic [39:0] square_acc;
  logic [9:0]  sign_changes;
  logic [24:0] mag_acc;
  logic [33:0] weighted_acc;
  logic        prev_nonneg;

  int  failures      = 0;
  int  samples_taken = 0;
  int  frames_scored = 0;
  int  energy_hits   = 0;
  int  crossing_hits = 0;
  int  centroid_hits = 0;
  int  full_scores   = 0;
  int  overlong      = 0;
  int  cycle_count   = 0;
  bit  sample_taken  = 1'b0;
  int  send_gap      = 0;
  int  stall_left    = 0;
  int  hold_left     = 0;
  bit  hold_done     = 1'b0;

  frame_voice_activity_score #(
    .MAX_FRAME(FRAME_CAP)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .last_in_frame(last_in_frame),
    .score_valid  (score_valid),
    .score_ready  (score_ready),
    .score_tenths (score_tenths),
    .energy_ok    (energy_ok),
    .crossing_ok  (crossing_ok),
    .centroid_ok  (centroid_ok)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // clear the predicted frame
  task automatic clear_frame_model();
    frame_len    = '0;
    square_acc   = '0;
    sign_changes = '0;
    mag_acc      = '0;
    weighted_acc = '0;
    prev_nonneg  = 1'b0;
  endtask

  // accumulate one sample and score the frame on its last sample
  task automatic score_frame_step(input logic signed [15:0] smp, input logic last);
    logic [63:0]  raw;
    logic [63:0]  mag;
    logic [63:0]  n;
    logic [63:0]  full_sq;
    logic [63:0]  mn;
    logic [63:0]  w5;
    logic         nonneg;
    frame_score_t res;
    raw    = {48'd0, smp};
    nonneg = (smp >= 0);
    mag    = nonneg ? raw : 64'd65536 - raw;
    if (frame_len < FRAME_CAP) begin
      if (frame_len != 0 && nonneg != prev_nonneg)
        sign_changes = sign_changes + 1'b1;
      square_acc   = square_acc + 40'(mag * mag);
      mag_acc      = mag_acc + 25'(mag);
      weighted_acc = weighted_acc + 34'(mag * frame_len);
      prev_nonneg  = nonneg;
      frame_len    = frame_len + 1'b1;
    end
    if (last) begin
      n       = 64'(frame_len);
      full_sq = n << 30;
      res.energy = (64'(square_acc) * 10000 > full_sq) &&
                   (64'(square_acc) * 100 < 9 * full_sq);
      res.crossing = (n >= 2) && (64'(sign_changes) * 50 > n - 1) &&
                     (64'(sign_changes) * 5 < n - 1);
      mn = 64'(mag_acc) * n;
      w5 = 64'(weighted_acc) * 5;
      res.centroid = (mag_acc != 0) && (w5 > mn) && (w5 < 4 * mn);
      res.score = 4'(W_ENERGY * res.energy + W_CROSSING * res.crossing +
                     W_CENTROID * res.centroid);
      expected_scores.push_back(res);
      frames_scored++;
      energy_hits   += res.energy;
      crossing_hits += res.crossing;
      centroid_hits += res.centroid;
      if (res.energy && res.crossing && res.centroid) full_scores++;
      clear_frame_model();
    end
  endtask

  // compare one score transaction with the oldest expectation
  task automatic check_frame_score();
    frame_score_t want;
    if (expected_scores.size() == 0) begin
      $error("unexpected score transaction: score_tenths %0d", score_tenths);
      failures++;
    end else begin
      want = expected_scores.pop_front();
      if (score_tenths !== want.score) begin
        $error("score_tenths: expected %0d, got %0d", want.score, score_tenths);
        failures++;
      end
      if (energy_ok !== want.energy) begin
        $error("energy_ok: expected %0d, got %0d", want.energy, energy_ok);
        failures++;
      end
      if (crossing_ok !== want.crossing) begin
        $error("crossing_ok: expected %0d, got %0d", want.crossing, crossing_ok);
        failures++;
      end
      if (centroid_ok !== want.centroid) begin
        $error("centroid_ok: expected %0d, got %0d", want.centroid, centroid_ok);
        failures++;
      end
    end
  endtask

  task automatic queue_sample(input logic signed [15:0] v, input logic last);
    audio_txn_t t;
    t.value = v;
    t.last  = last;
    pending_samples.push_back(t);
  endtask

  // one frame with random level, sign-change rate and envelope
  task automatic queue_random_frame(input int len);
    int  level;
    int  flip_pct;
    int  shape;
    int  mag;
    bit  neg;
    bit  raw_noise;
    logic signed [15:0] v;
    raw_noise = 1'b0;
    level     = 0;
    case ($urandom_range(0, 5))
      0: level = 0;
      1: level = 400;
      2: level = 4000;
      3: level = 9000;
      4: level = 12000;
      default: raw_noise = 1'b1;
    endcase
    case ($urandom_range(0, 3))
      0: flip_pct = 0;
      1: flip_pct = 5;
      2: flip_pct = 15;
      default: flip_pct = 50;
    endcase
    shape = $urandom_range(0, 3);
    neg   = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < flip_pct) neg = ~neg;
      if (raw_noise) begin
        v = 16'($urandom);
      end else begin
        mag = $urandom_range(0, level);
        case (shape)
          1: mag = mag * (i + 1) / len;
          2: mag = mag * (len - i) / len;
          3: if (i < len / 4 || i >= 3 * len / 4) mag = mag / 8;
          default: ;
        endcase
        v = neg ? -16'(mag) : 16'(mag);
      end
      queue_sample(v, i == len - 1);
    end
  endtask

  // stimulus: directed frames then random frames
  initial begin
    int base;
    int pick;
    clear_frame_model();
    // silent one-sample frame and one-sample energy edges
    queue_sample(16'sd0, 1'b1);
    queue_sample(16'sd327, 1'b1);
    queue_sample(16'sd328, 1'b1);
    queue_sample(-16'sd9830, 1'b1);
    queue_sample(-16'sd9831, 1'b1);
    // centroid exactly at the low edge, most negative sample
    queue_sample(16'sd0, 1'b0);
    queue_sample(-16'sd32768, 1'b0);
    queue_sample(16'sd0, 1'b0);
    queue_sample(16'sd0, 1'b0);
    queue_sample(16'sd0, 1'b1);
    // centroid just inside the high edge, most positive sample
    queue_sample(-16'sd1, 1'b0);
    queue_sample(-16'sd1, 1'b0);
    queue_sample(16'sd0, 1'b0);
    queue_sample(16'sd0, 1'b0);
    queue_sample(16'sd32767, 1'b1);
    // a frame that passes all three tests
    for (int i = 0; i < 12; i++)
      queue_sample((i >= 4 && i < 8) ? -16'sd3000 : 16'sd3000, i == 11);
    // random part, opened by a frame longer than the cap
    base = pending_samples.size();
    queue_random_frame(FRAME_CAP + $urandom_range(1, 20));
    overlong++;
    while (pending_samples.size() - base < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        queue_random_frame($urandom_range(1, 4));
      end else if (pick < 98) begin
        queue_random_frame($urandom_range(5, 32));
      end else begin
        queue_random_frame(FRAME_CAP + $urandom_range(1, 20));
        overlong++;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_samples.size() != 0 || sample_valid) @(posedge clk);
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples in %0d frames, %0d of them over the frame cap",
             samples_taken, frames_scored, overlong);
    $display("energy passed %0d, crossing %0d, centroid %0d, all three %0d",
             energy_hits, crossing_hits, centroid_hits, full_scores);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // monitor: predict on accepted samples, check accepted scores
  always @(posedge clk) begin
    cycle_count++;
    if (rst) begin
      sample_taken = 1'b0;
    end else begin
      sample_taken = sample_valid && sample_ready;
      if (sample_taken) begin
        samples_taken++;
        score_frame_step(sample, last_in_frame);
      end
      if (score_valid && score_ready) check_frame_score();
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // sample driver with random gaps, none in the tail or in calm stretches
  always @(negedge clk) begin
    audio_txn_t t;
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (sample_valid && !sample_taken) begin
      // hold the transaction until it is taken
    end else if (send_gap > 0) begin
      sample_valid <= 1'b0;
      send_gap--;
    end else if (pending_samples.size() != 0) begin
      t = pending_samples.pop_front();
      sample_valid  <= 1'b1;
      sample        <= t.value;
      last_in_frame <= t.last;
      if (pending_samples.size() > TAIL_ITEMS && ((cycle_count >> 8) % 3) != 1 &&
          $urandom_range(0, 5) == 0)
        send_gap = $urandom_range(1, 15);
    end else begin
      sample_valid <= 1'b0;
    end
  end

  // score receiver: random stalls plus one long hold-off to back up the pipeline
  always @(negedge clk) begin
    if (rst) begin
      score_ready <= 1'b0;
    end else if (!hold_done && samples_taken >= HOLD_TRIGGER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      score_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      score_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      score_ready <= 1'b0;
    end else if (pending_samples.size() > TAIL_ITEMS && ((cycle_count >> 8) % 3) != 2 &&
                 $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      score_ready <= 1'b0;
    end else begin
      score_ready <= 1'b1;
    end
  end

endmodule

// File: frame_voice_activity_score.f
src/fvas_pkg.sv
src/frame_voice_activity_score.sv
bench/frame_voice_activity_score_tb.sv
